// File: hw/rtl/spoly_pkg.sv
package spoly_pkg;

  // Command codes carried on the input channel; codes 6 and 7 are ignored.
  typedef enum logic [2:0] {
    FUNC_LOAD_A = 3'd0,
    FUNC_LOAD_B = 3'd1,
    FUNC_CLEAR  = 3'd2,
    FUNC_ADD    = 3'd3,
    FUNC_SUB    = 3'd4,
    FUNC_MUL    = 3'd5
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_SCAN,
    ST_EMIT,
    ST_MUL_ROW,
    ST_MUL_PAIR,
    ST_MUL_PROD,
    ST_MUL_ACC
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // latch the accepted input item
    logic clear;      // empty both stores and the product store
    logic init_as;    // start an add/subtract scan at the top exponent
    logic init_mul;   // start a product walk, drop old product terms
    logic init_res;   // start the product result scan
    logic load_rd;    // read the addressed A or B entry
    logic load_wr;    // write back the accumulated load
    logic scan_rd;    // read the entries at the scan exponent
    logic emit;       // load the output register
    logic scan_dec;   // step the scan exponent down
    logic pair_rd;    // read A[i], B[j] and the product sum at i+j
    logic pair_mult;  // register the product
    logic pair_wr;    // accumulate the product into its sum
    logic pair_step;  // next B index, wrapping into the next A row
    logic row_step;   // skip to the next A row
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    func_e in_func;   // command code on the input channel
    logic  exp_ok;    // latched load exponent lies inside the store
    logic  scan_hit;  // a term is present at the scan exponent
    logic  scan_zero; // scan exponent is zero
    logic  out_free;  // output register can take a term this cycle
    logic  a_hit;     // A term present at the row index
    logic  b_hit;     // B term present at the column index
    logic  i_end;     // row index at its top
    logic  j_end;     // column index at its top
  } stat_t;

endpackage

// File: hw/rtl/sparse_poly_add_sub_mul.sv
// Sparse polynomial unit with Q16.16 coefficients. Each input transfer is a
// command: load a term into store A or B (a repeated exponent adds to the
// held coefficient, saturating at 32 bits; an exponent of MAX_TERMS or more
// is dropped), clear both stores, or form A+B, A-B or A*B. A result is sent
// as a run of terms in descending exponent order with last_term_o on the
// closing term; every exponent present in the result is sent, zero
// coefficients included, and an empty result sends nothing. Products are
// floored to Q16.16, summed in 48 bits with saturation and saturated to 32
// bits on output. One command is handled at a time; the output register
// lets the next command be accepted while the closing term of a run still
// waits. Steps per command: clear acts as it is accepted; load captures,
// reads the store entry and writes it back. Add and subtract capture, then
// scan the MAX_TERMS exponents from the top down, with an emit step for
// each emitted term that waits while the output register is full. Multiply
// captures and walks the A rows: an empty row is passed over, a populated
// row visits all MAX_TERMS column slots, and each present pair is read,
// multiplied and accumulated into the product RAM by one read-modify-write;
// then the product scan covers 2*MAX_TERMS-1 exponents with an emit step
// per emitted term. The single 32x32 multiplier and the one read and one
// write port of the product RAM set this schedule.
module sparse_poly_add_sub_mul #(
  parameter int unsigned MAX_TERMS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         func_i,
  input  logic [4:0]         term_exponent_i,
  input  logic signed [31:0] term_coef_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [5:0]         result_exponent_o,
  output logic signed [31:0] result_coef_o,
  output logic               last_term_o
);

  import spoly_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencing of loads, scans and the product walk
  spoly_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // stores, multiplier, accumulator and output register
  spoly_dpath #(.MAX_TERMS(MAX_TERMS)) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .func_i            (func_i),
    .term_exponent_i   (term_exponent_i),
    .term_coef_i       (term_coef_i),
    .out_stall_i       (out_stall_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_valid_o       (out_valid_o),
    .result_exponent_o (result_exponent_o),
    .result_coef_o     (result_coef_o),
    .last_term_o       (last_term_o)
  );

endmodule

// File: hw/rtl/spoly_ram.sv
module spoly_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/spoly_ctrl.sv
module spoly_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  spoly_pkg::stat_t stat_i,
  output spoly_pkg::cmd_t  cmd_o
);

  import spoly_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          unique case (stat_i.in_func)
            FUNC_LOAD_A, FUNC_LOAD_B: begin
              cmd_o.capture = 1'b1;
              state_d       = ST_LOAD_RD;
            end
            FUNC_CLEAR: begin
              cmd_o.clear = 1'b1;
            end
            FUNC_ADD, FUNC_SUB: begin
              cmd_o.capture = 1'b1;
              cmd_o.init_as = 1'b1;
              state_d       = ST_SCAN;
            end
            FUNC_MUL: begin
              cmd_o.capture  = 1'b1;
              cmd_o.init_mul = 1'b1;
              state_d        = ST_MUL_ROW;
            end
            default: begin
            end
          endcase
        end
      end

      ST_LOAD_RD: begin
        if (stat_i.exp_ok) begin
          cmd_o.load_rd = 1'b1;
          state_d       = ST_LOAD_WR;
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_LOAD_WR: begin
        cmd_o.load_wr = 1'b1;
        state_d       = ST_IDLE;
      end

      ST_SCAN: begin
        if (stat_i.scan_hit) begin
          cmd_o.scan_rd = 1'b1;
          state_d       = ST_EMIT;
        end else if (stat_i.scan_zero) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.scan_dec = 1'b1;
        end
      end

      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.scan_zero) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.scan_dec = 1'b1;
            state_d        = ST_SCAN;
          end
        end
      end

      ST_MUL_ROW: begin
        if (stat_i.a_hit) begin
          state_d = ST_MUL_PAIR;
        end else if (stat_i.i_end) begin
          cmd_o.init_res = 1'b1;
          state_d        = ST_SCAN;
        end else begin
          cmd_o.row_step = 1'b1;
        end
      end

      ST_MUL_PAIR, ST_MUL_ACC: begin
        if (state_q == ST_MUL_PAIR && stat_i.b_hit) begin
          cmd_o.pair_rd = 1'b1;
          state_d       = ST_MUL_PROD;
        end else begin
          cmd_o.pair_wr = (state_q == ST_MUL_ACC);
          if (stat_i.j_end && stat_i.i_end) begin
            cmd_o.init_res = 1'b1;
            state_d        = ST_SCAN;
          end else begin
            cmd_o.pair_step = 1'b1;
            state_d         = stat_i.j_end ? ST_MUL_ROW : ST_MUL_PAIR;
          end
        end
      end

      ST_MUL_PROD: begin
        cmd_o.pair_mult = 1'b1;
        state_d         = ST_MUL_ACC;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // product pipeline runs read, multiply, accumulate without gaps
  a_pair_mult: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pair_rd |=> cmd_o.pair_mult)
    else $error("product read not followed by multiply");

  a_pair_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pair_mult |=> cmd_o.pair_wr)
    else $error("multiply not followed by accumulate");

  a_idle_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> (state_q == ST_IDLE))
    else $error("input taken outside idle");

endmodule

// File: hw/rtl/spoly_dpath.sv
module spoly_dpath #(
  parameter int unsigned MAX_TERMS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [2:0]         func_i,
  input  logic [4:0]         term_exponent_i,
  input  logic signed [31:0] term_coef_i,
  input  logic               out_stall_i,
  input  spoly_pkg::cmd_t    cmd_i,
  output spoly_pkg::stat_t   stat_o,
  output logic               out_valid_o,
  output logic [5:0]         result_exponent_o,
  output logic signed [31:0] result_coef_o,
  output logic               last_term_o
);

  import spoly_pkg::*;

  localparam int unsigned RES_TERMS = 2 * MAX_TERMS - 1;
  localparam int unsigned IW = $clog2(MAX_TERMS);
  localparam int unsigned RW = $clog2(RES_TERMS);

  function automatic logic [31:0] sat33(input logic [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    return v[31:0];
  endfunction

  function automatic logic [47:0] sat49(input logic [48:0] v);
    if (v[48] != v[47]) begin
      return v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end
    return v[47:0];
  endfunction

  function automatic logic [31:0] sat48to32(input logic [47:0] v);
    if ((&v[47:31]) || !(|v[47:31])) begin
      return v[31:0];
    end
    return v[47] ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  func_e                func_q;
  logic [4:0]           lexp_q;
  logic [31:0]          lcoef_q;
  logic [IW-1:0]        i_q, j_q;
  logic [RW-1:0]        e_q;
  logic [MAX_TERMS-1:0] pa_q, pb_q;
  logic [RES_TERMS-1:0] pr_q;
  logic signed [63:0]   prod_q;
  logic                 res_valid_q;
  logic [5:0]           res_exp_q;
  logic [31:0]          res_coef_q;
  logic                 res_last_q;

  logic [IW-1:0] lidx, eidx;
  logic [RW-1:0] pidx;
  logic          is_mul, out_free;

  logic          a_re, b_re, p_re, a_we, b_we, p_we;
  logic [IW-1:0] a_raddr, b_raddr;
  logic [RW-1:0] p_raddr;
  logic [31:0]   a_rdata, b_rdata;
  logic [47:0]   p_rdata;

  logic [31:0]   load_old, load_sum;
  logic [47:0]   p_old, p_sum;
  logic [31:0]   av, bv, emit_coef;
  logic [32:0]   as_sum;
  logic          emit_last;
  logic [MAX_TERMS-1:0] lower_a;
  logic [RES_TERMS-1:0] lower_r;

  assign lidx     = lexp_q[IW-1:0];
  assign eidx     = e_q[IW-1:0];
  assign pidx     = RW'(i_q) + RW'(j_q);
  assign is_mul   = (func_q == FUNC_MUL);
  assign out_free = !res_valid_q || !out_stall_i;

  // read port steering
  assign a_re    = cmd_i.load_rd || cmd_i.pair_rd || (cmd_i.scan_rd && !is_mul);
  assign b_re    = a_re;
  assign p_re    = cmd_i.pair_rd || (cmd_i.scan_rd && is_mul);
  assign a_raddr = cmd_i.load_rd ? lidx : (cmd_i.scan_rd ? eidx : i_q);
  assign b_raddr = cmd_i.load_rd ? lidx : (cmd_i.scan_rd ? eidx : j_q);
  assign p_raddr = cmd_i.pair_rd ? pidx : e_q;

  // load accumulate, an absent entry counts as zero
  always_comb begin
    if (func_q == FUNC_LOAD_A) begin
      load_old = pa_q[lidx] ? a_rdata : 32'd0;
    end else begin
      load_old = pb_q[lidx] ? b_rdata : 32'd0;
    end
    load_sum = sat33({load_old[31], load_old} + {lcoef_q[31], lcoef_q});
  end

  assign a_we = cmd_i.load_wr && (func_q == FUNC_LOAD_A);
  assign b_we = cmd_i.load_wr && (func_q == FUNC_LOAD_B);

  // floored product is bits 63:16 of the full product
  assign p_old = pr_q[pidx] ? p_rdata : 48'd0;
  assign p_sum = sat49({p_old[47], p_old} + {prod_q[63], prod_q[63:16]});
  assign p_we  = cmd_i.pair_wr;

  always_comb begin
    for (int k = 0; k < MAX_TERMS; k++) begin
      lower_a[k] = (k < int'(e_q));
    end
    for (int k = 0; k < RES_TERMS; k++) begin
      lower_r[k] = (k < int'(e_q));
    end
  end

  always_comb begin
    av     = pa_q[eidx] ? a_rdata : 32'd0;
    bv     = pb_q[eidx] ? b_rdata : 32'd0;
    as_sum = (func_q == FUNC_SUB) ? ({av[31], av} - {bv[31], bv})
                                  : ({av[31], av} + {bv[31], bv});
    if (is_mul) begin
      emit_coef = sat48to32(p_rdata);
      emit_last = !(|(pr_q & lower_r));
    end else begin
      emit_coef = sat33(as_sum);
      emit_last = !(|((pa_q | pb_q) & lower_a));
    end
  end

  spoly_ram #(.WIDTH(32), .DEPTH(MAX_TERMS)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (lidx),
    .wdata_i (load_sum),
    .re_i    (a_re),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  spoly_ram #(.WIDTH(32), .DEPTH(MAX_TERMS)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (lidx),
    .wdata_i (load_sum),
    .re_i    (b_re),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  spoly_ram #(.WIDTH(48), .DEPTH(RES_TERMS)) u_ram_p (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (pidx),
    .wdata_i (p_sum),
    .re_i    (p_re),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_q      <= FUNC_LOAD_A;
      i_q         <= '0;
      j_q         <= '0;
      e_q         <= '0;
      pa_q        <= '0;
      pb_q        <= '0;
      pr_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        func_q <= func_e'(func_i);
      end
      if (cmd_i.clear) begin
        pa_q <= '0;
        pb_q <= '0;
        pr_q <= '0;
      end
      if (a_we) begin
        pa_q[lidx] <= 1'b1;
      end
      if (b_we) begin
        pb_q[lidx] <= 1'b1;
      end
      if (cmd_i.init_mul) begin
        pr_q <= '0;
        i_q  <= '0;
        j_q  <= '0;
      end
      if (cmd_i.pair_wr) begin
        pr_q[pidx] <= 1'b1;
      end
      if (cmd_i.pair_step) begin
        if (j_q == IW'(MAX_TERMS - 1)) begin
          j_q <= '0;
          i_q <= i_q + 1'b1;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
      if (cmd_i.row_step) begin
        i_q <= i_q + 1'b1;
        j_q <= '0;
      end
      if (cmd_i.init_as) begin
        e_q <= RW'(MAX_TERMS - 1);
      end else if (cmd_i.init_res) begin
        e_q <= RW'(RES_TERMS - 1);
      end else if (cmd_i.scan_dec) begin
        e_q <= e_q - 1'b1;
      end
      if (cmd_i.emit) begin
        res_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      lexp_q  <= term_exponent_i;
      lcoef_q <= term_coef_i;
    end
    if (cmd_i.pair_mult) begin
      prod_q <= $signed(a_rdata) * $signed(b_rdata);
    end
    if (cmd_i.emit) begin
      res_exp_q  <= 6'(e_q);
      res_coef_q <= emit_coef;
      res_last_q <= emit_last;
    end
  end

  assign stat_o.in_func   = func_e'(func_i);
  assign stat_o.exp_ok    = ({1'b0, lexp_q} < 6'(MAX_TERMS));
  assign stat_o.scan_hit  = is_mul ? pr_q[e_q] : (pa_q[eidx] || pb_q[eidx]);
  assign stat_o.scan_zero = (e_q == '0);
  assign stat_o.out_free  = out_free;
  assign stat_o.a_hit     = pa_q[i_q];
  assign stat_o.b_hit     = pb_q[j_q];
  assign stat_o.i_end     = (i_q == IW'(MAX_TERMS - 1));
  assign stat_o.j_end     = (j_q == IW'(MAX_TERMS - 1));

  assign out_valid_o       = res_valid_q;
  assign result_exponent_o = res_exp_q;
  assign result_coef_o     = res_coef_q;
  assign last_term_o       = res_last_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!res_valid_q || !out_stall_i))
    else $error("term emitted over a pending transfer");

  a_pair_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pair_wr |=> pr_q[$past(pidx)])
    else $error("accumulated product exponent not marked present");

  a_clear_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (pa_q == '0 && pb_q == '0 && pr_q == '0))
    else $error("clear left terms present");

endmodule
